// File: rtl/ptrmx_pkg.sv
// Shared constants and types for the persistent trie range max xor block.
`timescale 1ns / 1ps
package ptrmx_pkg;
    localparam int VALUE_BITS   = 25;
    localparam int MAX_VERSIONS = 4096;
    localparam int NODE_DEPTH   = 131072;

    localparam int OPERAND_W = 25;
    localparam int END_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int NODE_W    = $clog2(NODE_DEPTH);
    localparam int VER_W     = $clog2(MAX_VERSIONS + 1);
    localparam int LVL_W     = $clog2(VALUE_BITS + 1);
    localparam int VER_DEPTH = MAX_VERSIONS + 1;
    localparam int FULL_MARK = NODE_DEPTH - (VALUE_BITS + 1);
    localparam int INIT_LAST = VALUE_BITS + 1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [VER_W-1:0]  mark;
        logic [NODE_W-1:0] c1;
        logic [NODE_W-1:0] c0;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0]     root;
        logic [VALUE_BITS-1:0] pfx;
    } ver_t;

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_A_VER  = 13'b0000000000100,
        S_A_WR   = 13'b0000000001000,
        S_A_LEAF = 13'b0000000010000,
        S_Q_PRE  = 13'b0000000100000,
        S_Q_ROOT = 13'b0000001000000,
        S_Q_WANT = 13'b0000010000000,
        S_Q_DEC  = 13'b0000100000000,
        S_Q_LEAF = 13'b0001000000000,
        S_Q_PFX  = 13'b0010000000000,
        S_DONE   = 13'b0100000000000,
        S_SPARE  = 13'b1000000000000
    } state_t;
endpackage

// File: rtl/ptrmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ptrmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/persistent_trie_range_max_xor.sv
// Top level: persistent binary trie with range maximum xor queries.
// Append: one node write per trie level, then a leaf node write.
// Query: two dependent node reads per trie level.
// One word in work at a time; the next word is accepted only after the result moves to
// the outputs, which waits while a held result sees out_stall. Bad range or full: no trie walk.
// After reset an init pass builds version zero; input stalls meanwhile.
`timescale 1ns / 1ps
module persistent_trie_range_max_xor
    import ptrmx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [OPERAND_W-1:0] operand_value,
    input  logic [END_W-1:0]     left_end,
    input  logic [END_W-1:0]     right_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OPERAND_W-1:0] max_xor,
    output logic [STATUS_W-1:0]  status
);
    state_t state_reg, state_next;
    logic [NODE_W:0]       free_reg, free_next;
    logic [VER_W-1:0]      count_reg, count_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [NODE_W-1:0]     want_reg, want_next;
    logic [NODE_W-1:0]     alt_reg, alt_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VER_W-1:0]      low_reg, low_next;
    logic [END_W-1:0]      r_reg, r_next;
    logic [OPERAND_W-1:0]  res_x_reg, res_x_next;
    logic [STATUS_W-1:0]   res_s_reg, res_s_next;
    logic                  ov_reg, ov_next;
    logic [OPERAND_W-1:0]  mx_reg, mx_next;
    logic [STATUS_W-1:0]   st_reg, st_next;
    logic                  nz_reg;

    logic              n_we;
    logic [NODE_W-1:0] n_waddr, n_raddr;
    node_t             n_wdata, n_rdata, nrd;
    logic              v_we;
    logic [VER_W-1:0]  v_waddr, v_raddr;
    ver_t              v_wdata, v_rdata;
    logic              b;
    logic              take;
    logic [VER_W-1:0]  leaf_ver;
    logic [NODE_W-1:0] next_old;

    ptrmx_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_DEPTH)) u_node_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    ptrmx_ram #(.WIDTH($bits(ver_t)), .DEPTH(VER_DEPTH)) u_ver_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    assign nrd       = nz_reg ? '0 : n_rdata;
    assign b         = key_reg[lvl_reg];
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign max_xor   = mx_reg;
    assign status    = st_reg;

    always_comb
    begin
        state_next = state_reg;
        free_next  = free_reg;
        count_next = count_reg;
        node_next  = node_reg;
        want_next  = want_reg;
        alt_next   = alt_reg;
        lvl_next   = lvl_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        low_next   = low_reg;
        r_next     = r_reg;
        res_x_next = res_x_reg;
        res_s_next = res_s_reg;
        ov_next    = ov_reg & out_stall;
        mx_next    = mx_reg;
        st_next    = st_reg;
        n_we       = 1'b0;
        n_waddr    = node_reg;
        n_wdata    = '0;
        n_raddr    = '0;
        v_we       = 1'b0;
        v_waddr    = '0;
        v_wdata    = '0;
        v_raddr    = count_reg;
        take       = 1'b0;
        leaf_ver   = '0;
        next_old   = b ? nrd.c1 : nrd.c0;
        case (state_reg)
            S_INIT:
            begin
                n_we    = 1'b1;
                n_waddr = free_reg[NODE_W-1:0];
                n_wdata = '0;
                if (free_reg != (NODE_W+1)'(INIT_LAST))
                begin
                    n_wdata.c0 = free_reg[NODE_W-1:0] + 1'b1;
                end
                if (free_reg == (NODE_W+1)'(1))
                begin
                    v_we         = 1'b1;
                    v_waddr      = '0;
                    v_wdata.root = NODE_W'(1);
                    v_wdata.pfx  = '0;
                end
                free_next = free_reg + 1'b1;
                if (free_reg == (NODE_W+1)'(INIT_LAST))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next   = VALUE_BITS'(operand_value);
                    low_next   = VER_W'(left_end - 1'b1);
                    r_next     = right_end;
                    res_x_next = '0;
                    res_s_next = ST_OK;
                    if (!mode)
                    begin
                        if (count_reg >= VER_W'(MAX_VERSIONS) ||
                            free_reg > (NODE_W+1)'(FULL_MARK))
                        begin
                            res_s_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_VER;
                        end
                    end
                    else if (left_end == '0 || left_end > right_end ||
                             {1'b0, right_end} > ({1'b0, count_reg} + 1'b1))
                    begin
                        res_s_next = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_Q_PRE;
                    end
                end
            end
            S_A_VER:
            begin
                key_next     = v_rdata.pfx ^ val_reg;
                v_we         = 1'b1;
                v_waddr      = count_reg + 1'b1;
                v_wdata.pfx  = v_rdata.pfx ^ val_reg;
                v_wdata.root = free_reg[NODE_W-1:0];
                node_next    = free_reg[NODE_W-1:0];
                lvl_next     = LVL_W'(VALUE_BITS - 1);
                n_raddr      = v_rdata.root;
                state_next   = S_A_WR;
            end
            S_A_WR:
            begin
                n_we         = 1'b1;
                n_wdata.mark = count_reg + 1'b1;
                if (b)
                begin
                    n_wdata.c1 = node_reg + 1'b1;
                    n_wdata.c0 = nrd.c0;
                end
                else
                begin
                    n_wdata.c0 = node_reg + 1'b1;
                    n_wdata.c1 = nrd.c1;
                end
                node_next = node_reg + 1'b1;
                n_raddr   = next_old;
                if (lvl_reg == '0)
                begin
                    state_next = S_A_LEAF;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            S_A_LEAF:
            begin
                n_we         = 1'b1;
                n_wdata.mark = count_reg + 1'b1;
                count_next   = count_reg + 1'b1;
                free_next    = {1'b0, node_reg} + 1'b1;
                state_next   = S_DONE;
            end
            S_Q_PRE:
            begin
                key_next   = v_rdata.pfx ^ val_reg;
                v_raddr    = VER_W'(r_reg - 1'b1);
                state_next = S_Q_ROOT;
            end
            S_Q_ROOT:
            begin
                node_next  = v_rdata.root;
                n_raddr    = v_rdata.root;
                lvl_next   = LVL_W'(VALUE_BITS - 1);
                state_next = S_Q_WANT;
            end
            S_Q_WANT:
            begin
                want_next  = b ? nrd.c0 : nrd.c1;
                alt_next   = next_old;
                n_raddr    = b ? nrd.c0 : nrd.c1;
                state_next = S_Q_DEC;
            end
            S_Q_DEC:
            begin
                take      = (want_reg != '0) && (n_rdata.mark >= low_reg);
                node_next = take ? want_reg : alt_reg;
                n_raddr   = take ? want_reg : alt_reg;
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_LEAF;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_Q_WANT;
                end
            end
            S_Q_LEAF:
            begin
                if (node_reg != '0 && n_rdata.mark <= count_reg)
                begin
                    leaf_ver = n_rdata.mark;
                end
                v_raddr    = leaf_ver;
                state_next = S_Q_PFX;
            end
            S_Q_PFX:
            begin
                res_x_next = OPERAND_W'(v_rdata.pfx ^ key_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    mx_next    = res_x_reg;
                    st_next    = res_s_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            free_reg  <= (NODE_W+1)'(1);
            count_reg <= '0;
            ov_reg    <= 1'b0;
            nz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            nz_reg    <= (n_raddr == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        want_reg  <= want_next;
        alt_reg   <= alt_next;
        lvl_reg   <= lvl_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        low_reg   <= low_next;
        r_reg     <= r_next;
        res_x_reg <= res_x_next;
        res_s_reg <= res_s_next;
        mx_reg    <= mx_next;
        st_reg    <= st_next;
    end
endmodule
